// ----- rtl/avmt_pkg.sv -----
package avmt_pkg;

    localparam int NUM_LANES  = 4;
    localparam int COMP_W     = 32;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = NUM_LANES * COEF_W;
    localparam int PROD_W     = COMP_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 12;
    localparam int Q_W        = SUM_W - FRAC_SHIFT;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;

    localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    // w value used for a position transform: 1.0 in Q16.16
    localparam logic [COMP_W-1:0] W_ONE = 32'h0001_0000;

    typedef enum logic [1:0] {
        FUNC_POSITION  = 2'd0,
        FUNC_DIRECTION = 2'd1,
        FUNC_FULL      = 2'd2
    } func_t;

    typedef struct packed {
        logic valid;
        logic full;
    } ctl_t;

endpackage

// ----- rtl/affine_vector_matrix_transform.sv -----
// pipeline: an accepted transaction passes the operand, product, sum and clip registers,
// and its result then shows with done high
// throughput: one transaction per cycle, set by the four lanes of four multipliers
// busy stays low; the receiver cannot stall, so results are never held off
// reset: rst_n clears the pipeline valid bits and loads the identity matrix
module affine_vector_matrix_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           func,
    input  logic signed [avmt_pkg::COMP_W-1:0]   in_x,
    input  logic signed [avmt_pkg::COMP_W-1:0]   in_y,
    input  logic signed [avmt_pkg::COMP_W-1:0]   in_z,
    input  logic signed [avmt_pkg::COMP_W-1:0]   in_w,
    output logic                                 done,
    output logic signed [avmt_pkg::COMP_W-1:0]   out_x,
    output logic signed [avmt_pkg::COMP_W-1:0]   out_y,
    output logic signed [avmt_pkg::COMP_W-1:0]   out_z,
    output logic signed [avmt_pkg::COMP_W-1:0]   out_w,
    output logic                                 saturated,
    input  logic                                 wr_en,
    input  logic [avmt_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [avmt_pkg::ROW_W-1:0]           wr_data
);
    import avmt_pkg::*;

    logic [ROW_W-1:0]                 row_reg [NUM_LANES];
    logic [NUM_LANES-1:0][COMP_W-1:0] vec_reg;
    logic [NUM_LANES-1:0][COMP_W-1:0] vec_next;
    ctl_t                             ctl_a_reg;
    ctl_t                             ctl_b_reg;
    ctl_t                             ctl_c_reg;
    ctl_t                             ctl_next;
    logic                             accept;
    logic signed [SUM_W-1:0]          lane_sum [NUM_LANES];
    logic [NUM_LANES-1:0][COMP_W-1:0] res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
            row_reg[3] <= ROW3_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ROW0: row_reg[0] <= wr_data;
                REG_ROW1: row_reg[1] <= wr_data;
                REG_ROW2: row_reg[2] <= wr_data;
                REG_ROW3: row_reg[3] <= wr_data;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        vec_next[0]    = in_x;
        vec_next[1]    = in_y;
        vec_next[2]    = in_z;
        ctl_next.valid = accept;
        case (func)
            FUNC_POSITION:
            begin
                vec_next[3]   = W_ONE;
                ctl_next.full = 1'b0;
            end
            FUNC_DIRECTION:
            begin
                vec_next[3]   = '0;
                ctl_next.full = 1'b0;
            end
            default:
            begin
                vec_next[3]   = in_w;
                ctl_next.full = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vec_reg <= vec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    // one lane per output column
    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane
        logic [NUM_LANES-1:0][COEF_W-1:0] col;

        for (genvar r = 0; r < NUM_LANES; r++)
        begin : g_row
            assign col[r] = row_reg[r][c*COEF_W +: COEF_W];
        end

        avmt_lane u_lane (
            .clk  (clk),
            .vec  (vec_reg),
            .coef (col),
            .sum  (lane_sum[c])
        );
    end

    avmt_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_c_reg),
        .sum       (lane_sum),
        .res       (res),
        .saturated (saturated),
        .done      (done)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];
    assign out_w = res[3];

endmodule

// ----- rtl/avmt_lane.sv -----
module avmt_lane (
    input  logic                                                   clk,
    input  logic [avmt_pkg::NUM_LANES-1:0][avmt_pkg::COMP_W-1:0]   vec,
    input  logic [avmt_pkg::NUM_LANES-1:0][avmt_pkg::COEF_W-1:0]   coef,
    output logic signed [avmt_pkg::SUM_W-1:0]                      sum
);
    import avmt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [NUM_LANES];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    // one multiplier per row, registered
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < NUM_LANES; r++)
        begin
            prod_reg[r] <= $signed(vec[r]) * $signed(coef[r]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < NUM_LANES; r++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// ----- rtl/avmt_merge.sv -----
module avmt_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  avmt_pkg::ctl_t                         ctl,
    input  logic signed [avmt_pkg::SUM_W-1:0]      sum [avmt_pkg::NUM_LANES],
    output logic [avmt_pkg::NUM_LANES-1:0][avmt_pkg::COMP_W-1:0] res,
    output logic                                   saturated,
    output logic                                   done
);
    import avmt_pkg::*;

    logic [NUM_LANES-1:0][COMP_W-1:0] res_reg;
    logic [NUM_LANES-1:0][COMP_W-1:0] res_next;
    logic                             sat_reg;
    logic                             sat_next;
    logic                             done_reg;
    logic [Q_W-1:0]                   q;
    logic [Q_W-COMP_W:0]              hi;
    logic                             col_en;

    // floor shift, then clip to 32 bits; the w column is zero unless func is full
    always_comb
    begin
        res_next = '0;
        sat_next = 1'b0;
        q        = '0;
        hi       = '0;
        col_en   = 1'b0;
        for (int c = 0; c < NUM_LANES; c++)
        begin
            col_en = (c < NUM_LANES - 1) || ctl.full;
            q      = sum[c][SUM_W-1:FRAC_SHIFT];
            hi     = q[Q_W-1:COMP_W-1];
            if (col_en)
            begin
                if ((hi == '0) || (hi == '1))
                begin
                    res_next[c] = q[COMP_W-1:0];
                end
                else
                begin
                    sat_next = 1'b1;
                    res_next[c] = q[Q_W-1] ? {1'b1, {(COMP_W-1){1'b0}}}
                                           : {1'b0, {(COMP_W-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
        end
    end

    assign res       = res_reg;
    assign saturated = sat_reg;
    assign done      = done_reg;

endmodule
